>>> sv/prv_pkg.sv
// Shared types, codes and helpers for the packet receive validator.
package prv_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_START_CHAR   = 2'd0;
	localparam logic [1:0] REG_END_CHAR     = 2'd1;
	localparam logic [1:0] REG_CHECK_ENABLE = 2'd2;

	// Result kinds
	localparam logic RK_BODY    = 1'b0;
	localparam logic RK_VERDICT = 1'b1;

	// Verdict codes
	localparam logic [2:0] VD_OK        = 3'd0;
	localparam logic [2:0] VD_NO_START  = 3'd1;
	localparam logic [2:0] VD_TOO_SHORT = 3'd2;
	localparam logic [2:0] VD_BAD_LEN   = 3'd3;
	localparam logic [2:0] VD_BAD_TYPE  = 3'd4;
	localparam logic [2:0] VD_BAD_SUM   = 3'd5;

	// Packet type characters
	localparam logic [7:0] TYPE_DATA   = 8'h44;
	localparam logic [7:0] TYPE_STATUS = 8'h53;
	localparam logic [7:0] TYPE_ERROR  = 8'h45;

	// Start, two length digits, type, four checksum digits, end
	localparam int unsigned MIN_PACKET_LEN = 9;

	typedef struct packed {
		logic [7:0] start_char;
		logic [7:0] end_char;
		logic       check_enable;
	} cfg_t;

	// Received byte with its classification
	typedef struct packed {
		logic [7:0] data;
		logic       is_start;
		logic       is_end;
		logic [3:0] hex;
		logic       hex_bad;
		logic       type_ok;
	} cls_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [2:0] code;
	} res_t;

	// {bad, value} for an uppercase hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] d);
		logic [4:0] r;
		if (d >= 8'h30 && d <= 8'h39) begin
			r = {1'b0, 4'(d - 8'h30)};
		end else if (d >= 8'h41 && d <= 8'h46) begin
			r = {1'b0, 4'(d - 8'h37)};
		end else begin
			r = 5'b1_0000;
		end
		return r;
	endfunction

	// rotate left by one, then add the byte
	function automatic logic [15:0] sum_step(input logic [15:0] s, input logic [7:0] b);
		return {s[14:0], s[15]} + {8'h00, b};
	endfunction

endpackage

>>> sv/prv_fifo.sv
// Small register queue with first-word-fall-through read.
module prv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> sv/prv_front.sv
// Front end: classifies each received byte against the configuration.
module prv_front (
	input  logic [7:0]     line_byte,
	input  prv_pkg::cfg_t  cfg,
	output prv_pkg::cls_t  cls
);
	import prv_pkg::*;

	logic [4:0] hx;

	always_comb begin
		hx           = hex_decode(line_byte);
		cls.data     = line_byte;
		cls.is_start = line_byte == cfg.start_char;
		cls.is_end   = line_byte == cfg.end_char;
		cls.hex      = hx[3:0];
		cls.hex_bad  = hx[4];
		cls.type_ok  = line_byte == TYPE_DATA || line_byte == TYPE_STATUS
		            || line_byte == TYPE_ERROR;
	end

endmodule

>>> sv/prv_back.sv
// Back end: packet state, checksum, tail delay line and verdicts.
module prv_back #(
	parameter int BUFFER_BYTES = 384
) (
	input  logic           clk,
	input  logic           arst_n,
	input  prv_pkg::cfg_t  cfg,
	input  prv_pkg::cls_t  cls,
	input  logic           cls_empty,
	output logic           cls_pop,
	output logic           res_push,
	output prv_pkg::res_t  res,
	input  logic           res_full
);
	import prv_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int LW = (CW > 8) ? CW : 8;

	logic          go;
	logic          in_packet_q, in_packet_d, inpk;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] pos_q, pos_d, pos_c, pos_n, len;
	logic [15:0]   sum_q, sum_d, sum_c, sum_e;
	logic [7:0]    declen_q, declen_d, declen_c;
	logic          lbad_q, lbad_d, lbad_c;
	logic          tbad_q, tbad_d, tbad_c;
	logic          ovf, emit;
	logic          tail_wr, tail_shift;
	logic [1:0]    tail_idx;
	logic          dig_bad;
	logic [15:0]   digits;
	cls_t          tail_q [4];

	assign go       = !cls_empty && !res_full;
	assign cls_pop  = go;
	assign res_push = go && emit;

	always_comb begin
		// buffer full: the reading state restarts before this byte
		ovf      = cnt_q == CW'(BUFFER_BYTES);
		inpk     = in_packet_q && !ovf;
		pos_c    = ovf ? '0 : pos_q;
		sum_c    = ovf ? '0 : sum_q;
		declen_c = ovf ? '0 : declen_q;
		lbad_c   = ovf ? 1'b0 : lbad_q;
		tbad_c   = ovf ? 1'b0 : tbad_q;

		cnt_d       = ovf ? CW'(1) : cnt_q + 1'b1;
		in_packet_d = inpk;
		pos_d       = pos_c;
		sum_d       = sum_c;
		declen_d    = declen_c;
		lbad_d      = lbad_c;
		tbad_d      = tbad_c;
		tail_wr     = 1'b0;
		tail_shift  = 1'b0;
		pos_n       = pos_c + 1'b1;
		tail_idx    = 2'(pos_n[1:0] + 2'd1);
		len         = pos_n + 1'b1;
		sum_e       = sum_step(sum_c, cls.data);
		digits      = {tail_q[0].hex, tail_q[1].hex, tail_q[2].hex, tail_q[3].hex};
		dig_bad     = tail_q[0].hex_bad | tail_q[1].hex_bad
		            | tail_q[2].hex_bad | tail_q[3].hex_bad;
		emit        = 1'b0;
		res         = '0;

		if (!inpk) begin
			if (cls.is_end) begin
				emit     = 1'b1;
				res.kind = RK_VERDICT;
				res.code = cls.is_start ? VD_TOO_SHORT : VD_NO_START;
			end else if (cls.is_start) begin
				in_packet_d = 1'b1;
				pos_d       = '0;
				sum_d       = {8'h00, cls.data};
				declen_d    = '0;
				lbad_d      = 1'b0;
				tbad_d      = 1'b0;
			end
		end else begin
			pos_d = pos_n;
			if (cls.is_end) begin
				emit     = 1'b1;
				res.kind = RK_VERDICT;
				if (len < CW'(MIN_PACKET_LEN)) begin
					res.code = VD_TOO_SHORT;
				end else if (lbad_c || LW'(declen_c) != LW'(len)) begin
					res.code = VD_BAD_LEN;
				end else if (tbad_c) begin
					res.code = VD_BAD_TYPE;
				end else if (cfg.check_enable && (dig_bad || digits != sum_e)) begin
					res.code = VD_BAD_SUM;
				end else begin
					res.code = VD_OK;
				end
			end else if (pos_n == CW'(1) || pos_n == CW'(2)) begin
				sum_d    = sum_e;
				lbad_d   = lbad_c | cls.hex_bad;
				declen_d = {declen_c[3:0], cls.hex};
			end else begin
				if (pos_n == CW'(3)) begin
					tbad_d = !cls.type_ok;
				end
				if (pos_n < CW'(7)) begin
					tail_wr = 1'b1;
				end else begin
					// oldest tail byte leaves as body and enters the checksum
					tail_shift = 1'b1;
					sum_d      = sum_step(sum_c, tail_q[0].data);
					emit       = 1'b1;
					res.kind   = RK_BODY;
					res.data   = tail_q[0].data;
				end
			end
		end

		// a verdict ends the packet and empties the buffer count
		if (emit && res.kind == RK_VERDICT) begin
			in_packet_d = 1'b0;
			cnt_d       = '0;
			pos_d       = '0;
			sum_d       = '0;
			declen_d    = '0;
			lbad_d      = 1'b0;
			tbad_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			cnt_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			declen_q    <= '0;
			lbad_q      <= 1'b0;
			tbad_q      <= 1'b0;
		end else if (go) begin
			in_packet_q <= in_packet_d;
			cnt_q       <= cnt_d;
			pos_q       <= pos_d;
			sum_q       <= sum_d;
			declen_q    <= declen_d;
			lbad_q      <= lbad_d;
			tbad_q      <= tbad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && tail_wr) begin
			tail_q[tail_idx] <= cls;
		end else if (go && tail_shift) begin
			tail_q[0] <= tail_q[1];
			tail_q[1] <= tail_q[2];
			tail_q[2] <= tail_q[3];
			tail_q[3] <= cls;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BUFFER_BYTES))
		else $error("buffer count beyond limit");

	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == RK_VERDICT) |=> (!in_packet_q && cnt_q == '0))
		else $error("verdict did not close the packet");

	a_body_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == RK_BODY) |=> (in_packet_q && pos_q >= CW'(7)))
		else $error("body beat outside a packet body");

	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == RK_BODY) |-> res.code == VD_OK)
		else $error("body beat carries a verdict code");

endmodule

>>> sv/packet_receive_validator.sv
// Top level of the packet receive validator.
// Takes one line byte per cycle while full is low and gives back zero or one result beat per
// byte: body bytes from the type byte on, delayed by four bytes so the checksum digits never
// leave, then a verdict beat at the end character. Sustained rate is one byte per cycle while
// nothing stalls, set by the back end's state update (rotate-and-add checksum plus compares).
// An accepted byte is first registered in the two-entry classify queue; the back end, which
// works straight off that queue's head, then writes its result into the two-entry result
// queue when nothing stalls, and that queue's head drives the ports.
// Configuration is taken at any cycle but must only change while idle.
module packet_receive_validator #(
	parameter int BUFFER_BYTES = 384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] line_byte,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output logic       result_kind,
	output logic [7:0] body_byte,
	output logic [2:0] verdict,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import prv_pkg::*;

	cfg_t cfg_q;
	cls_t cls_in, cls_out;
	res_t res_in, res_out;
	logic [$bits(cls_t)-1:0] cls_raw;
	logic [$bits(res_t)-1:0] res_raw;
	logic cls_empty, cls_pop, res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char   <= 8'h01;
			cfg_q.end_char     <= 8'h0D;
			cfg_q.check_enable <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_CHAR:   cfg_q.start_char   <= cfg_data;
				REG_END_CHAR:     cfg_q.end_char     <= cfg_data;
				REG_CHECK_ENABLE: cfg_q.check_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	prv_front u_front (
		.line_byte (line_byte),
		.cfg       (cfg_q),
		.cls       (cls_in)
	);

	prv_fifo #(.WIDTH($bits(cls_t)), .DEPTH(2)) u_cls_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (cls_pop),
		.rdata  (cls_raw),
		.empty  (cls_empty)
	);

	assign cls_out = cls_t'(cls_raw);

	prv_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	prv_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_raw),
		.empty  (empty)
	);

	assign res_out     = res_t'(res_raw);
	assign result_kind = res_out.kind;
	assign body_byte   = res_out.data;
	assign verdict     = res_out.code;

endmodule
